// ===== src/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Segregated free-list allocator package
// Shared types, codes and the size-class lookup for the allocator and its
// heap memory.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int unsigned MEM_DEPTH   = 16384;
  localparam int unsigned MEM_AW      = 14;
  localparam int unsigned NUM_CLASSES = 12;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NO_MEM  = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  // Upper size bound of every class but the last one.
  localparam logic [16:0] CLASS_LIMIT [NUM_CLASSES-1] = '{
    17'd16, 17'd32, 17'd40, 17'd72, 17'd132, 17'd520,
    17'd1032, 17'd2056, 17'd3080, 17'd5128, 17'd7168
  };

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [15:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] granted_addr;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [MEM_AW-1:0] addr;
    logic [31:0]       wdata;
  } heap_req_t;

  function automatic logic [3:0] size_class(input logic [16:0] s);
    logic [3:0] c;
    logic       hit;
    c   = 4'(NUM_CLASSES - 1);
    hit = 1'b0;
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (!hit && (s <= CLASS_LIMIT[i])) begin
        c   = 4'(i);
        hit = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/segregated_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Segregated free-list allocator
// Heap allocator with boundary tags and twelve size-class free lists, run by
// a sequencer around one single-port heap word memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid_i/in_stall_o   | sfla_pkg::req_t
//  out     | output    | out_valid_o/out_stall_i | sfla_pkg::rsp_t
//
// One request at a time; every heap access goes through the single memory
// port, so the port sets the cost. A free costs more for each free neighbor
// that is merged. An allocate costs more with a split, for each list entry
// passed over and for each empty class passed. Growing the heap adds its own
// cost and more for each merged neighbor; the first request adds heap setup.
// No clearing pass: reset only clears the list heads and the control state.
// A stalled result sits in the output register while the next request is
// already being worked on.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator #(
  parameter int unsigned HEAP_BYTES = 65536,
  parameter int unsigned GROW_BYTES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sfla_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sfla_pkg::rsp_t   out_data_o
);

  localparam int unsigned HEAP_LIMIT = ((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536) & ~32'd7;
  localparam int unsigned WALK_CAP   = HEAP_LIMIT / 16;
  localparam int unsigned STEP_W     = $clog2(WALK_CAP + 1);
  localparam logic [16:0] GROW       = 17'(GROW_BYTES);
  localparam int unsigned NS         = 45;

  typedef enum logic [NS-1:0] {
    S_IDLE      = NS'(1) << 0,
    S_INIT0     = NS'(1) << 1,
    S_INIT1     = NS'(1) << 2,
    S_INIT2     = NS'(1) << 3,
    S_INIT3     = NS'(1) << 4,
    S_EXT0      = NS'(1) << 5,
    S_EXT1      = NS'(1) << 6,
    S_EXT2      = NS'(1) << 7,
    S_EXT_RET   = NS'(1) << 8,
    S_C0        = NS'(1) << 9,
    S_C1        = NS'(1) << 10,
    S_C2        = NS'(1) << 11,
    S_C3        = NS'(1) << 12,
    S_C4        = NS'(1) << 13,
    S_C5        = NS'(1) << 14,
    S_C6        = NS'(1) << 15,
    S_C7        = NS'(1) << 16,
    S_COAL_DONE = NS'(1) << 17,
    S_U0        = NS'(1) << 18,
    S_U1        = NS'(1) << 19,
    S_U2        = NS'(1) << 20,
    S_U3        = NS'(1) << 21,
    S_U4        = NS'(1) << 22,
    S_P0        = NS'(1) << 23,
    S_P1        = NS'(1) << 24,
    S_P2        = NS'(1) << 25,
    S_P3        = NS'(1) << 26,
    S_ALLOC     = NS'(1) << 27,
    S_FIT_HEAD  = NS'(1) << 28,
    S_FIT_CHK   = NS'(1) << 29,
    S_FIT_SZ    = NS'(1) << 30,
    S_FIT_NEXT  = NS'(1) << 31,
    S_ALLOC_EXT = NS'(1) << 32,
    S_PL0       = NS'(1) << 33,
    S_PL1       = NS'(1) << 34,
    S_PL2       = NS'(1) << 35,
    S_PL3       = NS'(1) << 36,
    S_PL4       = NS'(1) << 37,
    S_PL5       = NS'(1) << 38,
    S_PL6       = NS'(1) << 39,
    S_ALLOC_OK  = NS'(1) << 40,
    S_FREE_HDR  = NS'(1) << 41,
    S_FREE_CHK  = NS'(1) << 42,
    S_FREE_FTR  = NS'(1) << 43,
    S_DONE      = NS'(1) << 44
  } state_e;

  function automatic sfla_pkg::heap_req_t rd_op(input logic [15:0] a);
    rd_op = '{we: 1'b0, re: 1'b1, addr: a[15:2], wdata: 32'd0};
  endfunction

  function automatic sfla_pkg::heap_req_t wr_op(input logic [15:0] a, input logic [31:0] v);
    wr_op = '{we: 1'b1, re: 1'b0, addr: a[15:2], wdata: v};
  endfunction

  state_e state_q, state_d, ret_q;

  logic              act_q;
  logic [15:0]       rsize_q, addr_q, bp_q, prev_q, next_q, ubp_q, pbp_q, h_q, b_q;
  logic [15:0]       nx_q, pv_q;
  logic [16:0]       asize_q, size_q, csize_q, psize_q, extb_q;
  logic              pa_q;
  logic [3:0]        ucls_q, pcls_q, k_q;
  logic [STEP_W-1:0] steps_q;
  logic [16:0]       heap_top_q;
  logic              ready_q, first_q, in_ext_q, in_init_q;
  logic [15:0]       heads_q [sfla_pkg::NUM_CLASSES];
  logic              out_valid_q;
  sfla_pkg::rsp_t    out_q, res_q;

  sfla_pkg::heap_req_t mreq;
  logic [31:0]         rdata;

  sfla_heap_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .rdata_o(rdata)
  );

  // Combinational helpers.
  logic [16:0] rd_size, asize_c, rem;
  logic [15:0] prev_c;
  logic [17:0] ext_size;
  logic        ext_fits, split, fr_bad;
  logic [31:0] fr_size;
  logic [3:0]  rd_cls;

  always_comb begin
    rd_size  = {rdata[16:3], 3'b000};
    rd_cls   = sfla_pkg::size_class(rd_size);
    prev_c   = bp_q - rd_size[15:0];
    asize_c  = (rsize_q <= 16'd8) ? 17'd16 : ((17'(rsize_q) + 17'd15) & ~17'd7);
    ext_size = {16'(extb_q[16:2]) + 16'(extb_q[2]), 2'b00};
    ext_fits = (19'(heap_top_q) + 19'(ext_size)) <= 19'(HEAP_LIMIT);
    split    = 18'(csize_q) >= (18'(asize_q) + 18'd16);
    rem      = csize_q - asize_q;
    fr_size  = {rdata[31:3], 3'b000};
    fr_bad   = (addr_q[2:0] != 3'd0) || (addr_q < 16'd16) ||
               (17'(addr_q) >= heap_top_q) || !rdata[0] || (fr_size < 32'd16) ||
               ((33'(addr_q) + 33'(fr_size)) > 33'(heap_top_q));
  end

  // Sequencer: next state and memory access.
  always_comb begin
    state_d = state_q;
    mreq    = '{we: 1'b0, re: 1'b0, addr: '0, wdata: 32'd0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.action == sfla_pkg::ACT_FREE && in_data_i.block_addr == 16'd0) begin
            state_d = S_DONE;
          end else if (!ready_q) begin
            state_d = S_INIT0;
          end else if (in_data_i.action == sfla_pkg::ACT_FREE) begin
            state_d = S_FREE_HDR;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_INIT0: begin mreq = wr_op(16'd0, 32'd0);  state_d = S_INIT1; end
      S_INIT1: begin mreq = wr_op(16'd4, 32'd9);  state_d = S_INIT2; end
      S_INIT2: begin mreq = wr_op(16'd8, 32'd9);  state_d = S_INIT3; end
      S_INIT3: begin mreq = wr_op(16'd12, 32'd1); state_d = S_EXT0;  end
      S_EXT0: begin
        if (!ext_fits) begin
          state_d = S_EXT_RET;
        end else begin
          mreq    = wr_op(heap_top_q[15:0] - 16'd4, 32'(ext_size));
          state_d = S_EXT1;
        end
      end
      S_EXT1: begin
        mreq    = wr_op(16'(bp_q + size_q - 17'd8), 32'(size_q));
        state_d = S_EXT2;
      end
      S_EXT2: begin
        mreq    = wr_op(16'(bp_q + size_q - 17'd4), 32'd1);
        state_d = S_C0;
      end
      S_EXT_RET: begin
        if (in_init_q) begin
          state_d = (act_q == sfla_pkg::ACT_FREE) ? S_FREE_HDR : S_ALLOC;
        end else begin
          state_d = S_ALLOC_EXT;
        end
      end
      S_C0: begin
        if (first_q) begin
          state_d = S_P0;
        end else begin
          mreq    = rd_op(bp_q - 16'd4);
          state_d = S_C1;
        end
      end
      S_C1: begin mreq = rd_op(bp_q - 16'd8);     state_d = S_C2; end
      S_C2: begin mreq = rd_op(prev_c - 16'd4);   state_d = S_C3; end
      S_C3: begin mreq = rd_op(next_q - 16'd4);   state_d = S_C4; end
      S_C4: state_d = rdata[0] ? S_C5 : S_U0;
      S_C5: state_d = pa_q ? S_C6 : S_U0;
      S_C6: begin
        mreq    = wr_op(bp_q - 16'd4, 32'(size_q));
        state_d = S_C7;
      end
      S_C7: begin
        mreq    = wr_op(16'(bp_q + size_q - 17'd8), 32'(size_q));
        state_d = S_P0;
      end
      S_COAL_DONE: state_d = in_ext_q ? S_EXT_RET : S_DONE;
      S_U0: begin mreq = rd_op(ubp_q - 16'd4); state_d = S_U1; end
      S_U1: begin mreq = rd_op(ubp_q);         state_d = S_U2; end
      S_U2: begin mreq = rd_op(ubp_q + 16'd4); state_d = S_U3; end
      S_U3: begin
        if (rdata[15:0] != 16'd0) begin
          mreq = wr_op(rdata[15:0], 32'(nx_q));
        end
        state_d = S_U4;
      end
      S_U4: begin
        if (nx_q != 16'd0) begin
          mreq = wr_op(nx_q + 16'd4, 32'(pv_q));
        end
        state_d = ret_q;
      end
      S_P0: begin mreq = rd_op(pbp_q - 16'd4); state_d = S_P1; end
      S_P1: begin
        mreq    = wr_op(pbp_q, 32'(heads_q[rd_cls]));
        state_d = S_P2;
      end
      S_P2: begin mreq = wr_op(pbp_q + 16'd4, 32'd0); state_d = S_P3; end
      S_P3: begin
        if (h_q != 16'd0) begin
          mreq = wr_op(h_q + 16'd4, 32'(pbp_q));
        end
        state_d = ret_q;
      end
      S_ALLOC:    state_d = (rsize_q == 16'd0) ? S_DONE : S_FIT_HEAD;
      S_FIT_HEAD: state_d = S_FIT_CHK;
      S_FIT_CHK: begin
        if (steps_q >= STEP_W'(WALK_CAP)) begin
          state_d = S_EXT0;
        end else if (b_q == 16'd0) begin
          state_d = (k_q == 4'(sfla_pkg::NUM_CLASSES - 1)) ? S_EXT0 : S_FIT_HEAD;
        end else begin
          mreq    = rd_op(b_q - 16'd4);
          state_d = S_FIT_SZ;
        end
      end
      S_FIT_SZ: begin
        if (32'(asize_q) <= {rdata[31:3], 3'b000}) begin
          state_d = S_PL0;
        end else begin
          mreq    = rd_op(b_q);
          state_d = S_FIT_NEXT;
        end
      end
      S_FIT_NEXT:  state_d = S_FIT_CHK;
      S_ALLOC_EXT: state_d = (bp_q == 16'd0) ? S_DONE : S_PL0;
      S_PL0: begin mreq = rd_op(bp_q - 16'd4); state_d = S_PL1; end
      S_PL1: state_d = S_U0;
      S_PL2: begin
        if (split) begin
          mreq    = wr_op(bp_q - 16'd4, 32'(asize_q) | 32'd1);
          state_d = S_PL3;
        end else begin
          mreq    = wr_op(bp_q - 16'd4, 32'(csize_q) | 32'd1);
          state_d = S_PL6;
        end
      end
      S_PL3: begin
        mreq    = wr_op(16'(bp_q + asize_q - 17'd8), 32'(asize_q) | 32'd1);
        state_d = S_PL4;
      end
      S_PL4: begin
        mreq    = wr_op(16'(bp_q + asize_q - 17'd4), 32'(rem));
        state_d = S_PL5;
      end
      S_PL5: begin
        mreq    = wr_op(16'(bp_q + csize_q - 17'd8), 32'(rem));
        state_d = S_P0;
      end
      S_PL6: begin
        mreq    = wr_op(16'(bp_q + csize_q - 17'd8), 32'(csize_q) | 32'd1);
        state_d = S_ALLOC_OK;
      end
      S_ALLOC_OK: state_d = S_DONE;
      S_FREE_HDR: begin mreq = rd_op(addr_q - 16'd4); state_d = S_FREE_CHK; end
      S_FREE_CHK: begin
        if (fr_bad) begin
          state_d = S_DONE;
        end else begin
          mreq    = wr_op(addr_q - 16'd4, 32'(fr_size[16:0]));
          state_d = S_FREE_FTR;
        end
      end
      S_FREE_FTR: begin
        mreq    = wr_op(16'(addr_q + size_q - 17'd8), 32'(size_q));
        state_d = S_C0;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_top_q  <= '0;
      ready_q     <= 1'b0;
      first_q     <= 1'b1;
      in_ext_q    <= 1'b0;
      in_init_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < sfla_pkg::NUM_CLASSES; i++) begin
        heads_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !ready_q &&
              !(in_data_i.action == sfla_pkg::ACT_FREE && in_data_i.block_addr == 16'd0)) begin
            in_init_q <= 1'b1;
          end
        end
        S_INIT3: begin
          heap_top_q <= 17'd16;
          ready_q    <= 1'b1;
          in_ext_q   <= 1'b1;
        end
        S_EXT2:    heap_top_q <= heap_top_q + size_q;
        S_EXT_RET: begin
          in_ext_q  <= 1'b0;
          in_init_q <= 1'b0;
        end
        S_C0: begin
          if (first_q) begin
            first_q <= 1'b0;
          end
        end
        S_U3: begin
          if (rdata[15:0] == 16'd0) begin
            heads_q[ucls_q] <= nx_q;
          end
        end
        S_P3: heads_q[pcls_q] <= pbp_q;
        S_FIT_CHK: begin
          if ((steps_q >= STEP_W'(WALK_CAP)) ||
              (b_q == 16'd0 && k_q == 4'(sfla_pkg::NUM_CLASSES - 1))) begin
            in_ext_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        act_q   <= in_data_i.action;
        rsize_q <= in_data_i.request_size;
        addr_q  <= in_data_i.block_addr;
        extb_q  <= GROW;
        res_q   <= '{granted_addr: 16'd0, status: sfla_pkg::STATUS_IGNORED};
      end
      S_EXT0: begin
        bp_q   <= ext_fits ? heap_top_q[15:0] : 16'd0;
        size_q <= ext_size[16:0];
      end
      // After heap setup or growth the result is reset to ignored; after setup the request starts over.
      S_EXT_RET: res_q <= '{granted_addr: 16'd0, status: sfla_pkg::STATUS_IGNORED};
      S_C0: begin
        pbp_q <= bp_q;
        ret_q <= S_COAL_DONE;
      end
      S_C1: begin
        size_q <= rd_size;
        next_q <= bp_q + rd_size[15:0];
      end
      S_C2: prev_q <= prev_c;
      S_C3: begin
        pa_q    <= rdata[0];
        psize_q <= rd_size;
      end
      S_C4: begin
        if (!rdata[0]) begin
          size_q <= size_q + rd_size;
          ubp_q  <= next_q;
          ret_q  <= S_C5;
        end
      end
      S_C5: begin
        if (!pa_q) begin
          size_q <= size_q + psize_q;
          ubp_q  <= prev_q;
          bp_q   <= prev_q;
          ret_q  <= S_C6;
        end
      end
      S_C7: begin
        pbp_q <= bp_q;
        ret_q <= S_COAL_DONE;
      end
      S_COAL_DONE: res_q <= '{granted_addr: 16'd0, status: sfla_pkg::STATUS_DONE};
      S_U1: ucls_q <= rd_cls;
      S_U2: nx_q   <= rdata[15:0];
      S_U3: pv_q   <= rdata[15:0];
      S_P1: begin
        pcls_q <= rd_cls;
        h_q    <= heads_q[rd_cls];
      end
      S_ALLOC: begin
        asize_q <= asize_c;
        k_q     <= sfla_pkg::size_class(asize_c);
        steps_q <= '0;
      end
      S_FIT_HEAD: b_q <= heads_q[k_q];
      S_FIT_CHK: begin
        if (b_q == 16'd0 && k_q != 4'(sfla_pkg::NUM_CLASSES - 1)) begin
          k_q <= k_q + 4'd1;
        end
        extb_q <= (asize_q > GROW) ? asize_q : GROW;
      end
      S_FIT_SZ:    bp_q <= b_q;
      S_FIT_NEXT: begin
        b_q     <= rdata[15:0];
        steps_q <= steps_q + STEP_W'(1);
      end
      S_ALLOC_EXT: res_q <= '{granted_addr: 16'd0, status: sfla_pkg::STATUS_NO_MEM};
      S_PL1: begin
        csize_q <= rd_size;
        ubp_q   <= bp_q;
        ret_q   <= S_PL2;
      end
      S_PL5: begin
        pbp_q <= 16'(bp_q + asize_q);
        ret_q <= S_ALLOC_OK;
      end
      S_ALLOC_OK: res_q <= '{granted_addr: bp_q, status: sfla_pkg::STATUS_DONE};
      S_FREE_CHK: begin
        size_q <= fr_size[16:0];
      end
      S_FREE_FTR: bp_q <= addr_q;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_mem_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mreq.we && mreq.re))
    else $error("heap memory read and written in one cycle");

  a_heap_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heap_top_q[2:0] == 3'd0) && (heap_top_q <= 17'(HEAP_LIMIT)))
    else $error("heap top misaligned or past the limit");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted request left sequencer idle");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.granted_addr == 16'd0 ||
                     out_data_o.status == sfla_pkg::STATUS_DONE))
    else $error("address granted with failing status");
`endif

endmodule

// ===== src/sfla_heap_ram.sv =====
// ----------------------------------------------------------------------------
// Heap word memory
// Single-port word memory with one write, one read or both per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module sfla_heap_ram (
  input  logic                clk_i,
  input  sfla_pkg::heap_req_t req_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem_q [sfla_pkg::MEM_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
